// ===== rtl/midpoint_circle_rasterizer_defines.svh =====
`ifndef MIDPOINT_CIRCLE_RASTERIZER_DEFINES_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_DEFINES_SVH

// same-cycle implication
`define MCR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mcr assertion failed");

// next-cycle implication
`define MCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mcr assertion failed");

`endif

// ===== rtl/mcr_pkg.sv =====
`timescale 1ns / 1ps

package mcr_pkg;

   localparam int COORD_BITS_DEFAULT = 12;
   localparam int DEC_BITS = 18;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   localparam int DEC_INIT = 3;
   localparam int DEC_DIAG = 10;
   localparam int DEC_AXIS = 6;

   // index of the eighth mirrored point
   localparam logic [2:0] PT_LAST  = 3'd7;
   localparam logic [2:0] PT_FIRST = 3'd0;

   typedef struct packed {
      logic points;   // eight real points, else one idle reply
      logic finish;   // circle ends with this job
   } job_ctrl_type;

endpackage

// ===== rtl/mcr_walk.sv =====
`timescale 1ns / 1ps
`include "midpoint_circle_rasterizer_defines.svh"

module mcr_walk
   import mcr_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          command,
   input  logic [COORD_BITS-1:0]         center_x,
   input  logic [COORD_BITS-1:0]         center_y,
   input  logic [COORD_BITS-2:0]         radius,
   output job_ctrl_type                  job_ctrl,
   output logic [COORD_BITS-1:0]         job_cx,
   output logic [COORD_BITS-1:0]         job_cy,
   output logic signed [COORD_BITS:0]    job_x,
   output logic signed [COORD_BITS:0]    job_y
);

   localparam int WALK_BITS = COORD_BITS + 1;

   logic                        active_ff, active_in;
   logic signed [WALK_BITS-1:0] x_ff, x_in;
   logic signed [WALK_BITS-1:0] y_ff, y_in;
   logic signed [DEC_BITS-1:0]  d_ff, d_in;
   logic [COORD_BITS-1:0]       cx_ff, cx_in;
   logic [COORD_BITS-1:0]       cy_ff, cy_in;

   logic signed [WALK_BITS-1:0] x_inc;
   logic signed [WALK_BITS-1:0] y_dec;
   logic signed [DEC_BITS-1:0]  x_wide;
   logic signed [DEC_BITS-1:0]  y_wide;
   logic                        d_pos;
   logic                        finish;
   logic                        step_idle;

   always_comb begin
      x_inc  = x_ff + WALK_BITS'(1);
      y_dec  = y_ff - WALK_BITS'(1);
      d_pos  = !d_ff[DEC_BITS-1] && (d_ff != '0);
      x_wide = DEC_BITS'(x_inc);
      y_wide = DEC_BITS'(d_pos ? y_dec : y_ff);

      active_in = active_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      d_in      = d_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      finish    = 1'b0;
      job_ctrl  = '{points: 1'b0, finish: 1'b0};

      case (command)
         CMD_START: begin
            active_in = 1'b1;
            cx_in     = center_x;
            cy_in     = center_y;
            x_in      = '0;
            y_in      = WALK_BITS'(radius);
            d_in      = DEC_BITS'(DEC_INIT) - (DEC_BITS'(radius) << 1);
            job_ctrl  = '{points: 1'b1, finish: 1'b0};
         end
         default: begin
            if (active_ff) begin
               x_in = x_inc;
               if (d_pos) begin
                  y_in = y_dec;
                  d_in = d_ff + ((x_wide - y_wide) <<< 2) + DEC_BITS'(DEC_DIAG);
               end else begin
                  d_in = d_ff + (x_wide <<< 2) + DEC_BITS'(DEC_AXIS);
               end
               finish    = y_in < x_in;
               active_in = !finish;
               job_ctrl  = '{points: 1'b1, finish: finish};
            end
         end
      endcase
   end

   assign job_cx = cx_in;
   assign job_cy = cy_in;
   assign job_x  = x_in;
   assign job_y  = y_in;

   assign step_idle = (command == CMD_STEP) && !active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         x_ff      <= '0;
         y_ff      <= '0;
         d_ff      <= '0;
         cx_ff     <= '0;
         cy_ff     <= '0;
      end else if (accept) begin
         active_ff <= active_in;
         x_ff      <= x_in;
         y_ff      <= y_in;
         d_ff      <= d_in;
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
      end
   end

   `MCR_ASSERT_NEXT(a_finish_goes_idle, clock, reset, accept && job_ctrl.finish, !active_ff)
   `MCR_ASSERT_NEXT(a_start_activates, clock, reset, accept && command == CMD_START, active_ff)
   `MCR_ASSERT_IMPL(a_idle_step_reply, clock, reset, accept && step_idle, !job_ctrl.points)

endmodule

// ===== rtl/mcr_emit.sv =====
`timescale 1ns / 1ps
`include "midpoint_circle_rasterizer_defines.svh"

module mcr_emit
   import mcr_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_load,
   input  job_ctrl_type                  job_ctrl,
   input  logic [COORD_BITS-1:0]         job_cx,
   input  logic [COORD_BITS-1:0]         job_cy,
   input  logic signed [COORD_BITS:0]    job_x,
   input  logic signed [COORD_BITS:0]    job_y,
   output logic                          job_free,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_BITS+1:0]  rsp_pixel_x,
   output logic signed [COORD_BITS+1:0]  rsp_pixel_y,
   output logic                          rsp_pixel_valid,
   output logic                          rsp_last_of_step,
   output logic                          rsp_done_res
);

   localparam int WALK_BITS = COORD_BITS + 1;
   localparam int PIX_BITS  = COORD_BITS + 2;

   // held job
   logic                        busy_ff, busy_in;
   logic [2:0]                  idx_ff, idx_in;
   job_ctrl_type                ctrl_ff;
   logic [COORD_BITS-1:0]       cx_ff, cy_ff;
   logic signed [WALK_BITS-1:0] x_ff, y_ff;

   // output register
   logic                        valid_ff, valid_in;
   logic signed [PIX_BITS-1:0]  px_ff, px_in;
   logic signed [PIX_BITS-1:0]  py_ff, py_in;
   logic                        pv_ff, pv_in;
   logic                        last_ff, last_in;
   logic                        done_ff, done_in;

   logic                        load_out;
   logic                        idx_last;
   logic signed [PIX_BITS-1:0]  off_x, off_y;

   always_comb begin
      load_out = !valid_ff || !rsp_stall;
      idx_last = ctrl_ff.points ? (idx_ff == PT_LAST) : 1'b1;
      job_free = !busy_ff || (load_out && idx_last);

      // points 4..7 swap the roles of x and y
      off_x = PIX_BITS'(idx_ff[2] ? y_ff : x_ff);
      off_y = PIX_BITS'(idx_ff[2] ? x_ff : y_ff);

      valid_in = valid_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      pv_in    = pv_ff;
      last_in  = last_ff;
      done_in  = done_ff;
      if (load_out) begin
         valid_in = busy_ff;
         if (ctrl_ff.points) begin
            px_in = idx_ff[0] ? PIX_BITS'(cx_ff) - off_x : PIX_BITS'(cx_ff) + off_x;
            py_in = idx_ff[1] ? PIX_BITS'(cy_ff) - off_y : PIX_BITS'(cy_ff) + off_y;
         end else begin
            px_in = '0;
            py_in = '0;
         end
         pv_in   = ctrl_ff.points;
         last_in = idx_last;
         done_in = idx_last && ctrl_ff.finish;
      end

      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (job_load) begin
         busy_in = 1'b1;
         idx_in  = PT_FIRST;
      end else if (busy_ff && load_out) begin
         busy_in = !idx_last;
         idx_in  = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         idx_ff   <= PT_FIRST;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_load) begin
         ctrl_ff <= job_ctrl;
         cx_ff   <= job_cx;
         cy_ff   <= job_cy;
         x_ff    <= job_x;
         y_ff    <= job_y;
      end
      px_ff   <= px_in;
      py_ff   <= py_in;
      pv_ff   <= pv_in;
      last_ff <= last_in;
      done_ff <= done_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_pixel_x      = px_ff;
   assign rsp_pixel_y      = py_ff;
   assign rsp_pixel_valid  = pv_ff;
   assign rsp_last_of_step = last_ff;
   assign rsp_done_res     = done_ff;

   `MCR_ASSERT_IMPL(a_idle_job_single, clock, reset, busy_ff && !ctrl_ff.points, idx_ff == PT_FIRST)
   `MCR_ASSERT_IMPL(a_done_on_last, clock, reset, valid_ff && done_ff, last_ff && pv_ff)
   `MCR_ASSERT_IMPL(a_load_when_free, clock, reset, job_load, job_free)

endmodule

// ===== rtl/midpoint_circle_rasterizer.sv =====
`timescale 1ns / 1ps

// Midpoint circle rasterizer. A start transfer (command 0) latches center and
// radius and yields the eight mirrored points of (0, radius); each step
// transfer (command 1) advances the walk by one column and yields the next
// eight points, the eighth carrying done_res when the circle closes. A step
// with no circle in progress yields one reply with pixel_valid low. Points
// leave one per cycle from the output register while rsp_stall is low, so a
// circle item fills eight output slots and an idle reply one. The walk
// update happens at the input transfer, and the next item is taken in the
// same cycle that the previous item's last point enters the output register.

module midpoint_circle_rasterizer
   import mcr_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_command,
   input  logic [COORD_BITS-1:0]         req_center_x,
   input  logic [COORD_BITS-1:0]         req_center_y,
   input  logic [COORD_BITS-2:0]         req_radius,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_BITS+1:0]  rsp_pixel_x,
   output logic signed [COORD_BITS+1:0]  rsp_pixel_y,
   output logic                          rsp_pixel_valid,
   output logic                          rsp_last_of_step,
   output logic                          rsp_done_res
);

   logic                       accept;
   logic                       job_free;
   job_ctrl_type               job_ctrl;
   logic [COORD_BITS-1:0]      job_cx;
   logic [COORD_BITS-1:0]      job_cy;
   logic signed [COORD_BITS:0] job_x;
   logic signed [COORD_BITS:0] job_y;

   assign req_stall = !job_free;
   assign accept    = req_valid && job_free;

   mcr_walk #(
      .COORD_BITS (COORD_BITS)
   ) u_walk (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .command  (req_command),
      .center_x (req_center_x),
      .center_y (req_center_y),
      .radius   (req_radius),
      .job_ctrl (job_ctrl),
      .job_cx   (job_cx),
      .job_cy   (job_cy),
      .job_x    (job_x),
      .job_y    (job_y)
   );

   mcr_emit #(
      .COORD_BITS (COORD_BITS)
   ) u_emit (
      .clock            (clock),
      .reset            (reset),
      .job_load         (accept),
      .job_ctrl         (job_ctrl),
      .job_cx           (job_cx),
      .job_cy           (job_cy),
      .job_x            (job_x),
      .job_y            (job_y),
      .job_free         (job_free),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_pixel_valid  (rsp_pixel_valid),
      .rsp_last_of_step (rsp_last_of_step),
      .rsp_done_res     (rsp_done_res)
   );

endmodule

// ===== verif/midpoint_circle_rasterizer_test.sv =====
`timescale 1ns / 1ps

typedef struct {
   logic signed [13:0] x;
   logic signed [13:0] y;
   logic               pixel_valid;
   logic               last_of_step;
   logic               done_res;
} circle_pixel_type;

class circle_scoreboard;
   logic               walking;
   logic signed [12:0] walk_x;
   logic signed [12:0] walk_y;
   logic signed [17:0] decision;
   logic [11:0]        origin_x;
   logic [11:0]        origin_y;
   circle_pixel_type   pending_pixels[$];
   int                 errors;

   function new();
      walking = 1'b0;
      walk_x = '0;
      walk_y = '0;
      decision = '0;
      origin_x = '0;
      origin_y = '0;
      errors = 0;
   endfunction

   // eight mirrored points of the current walk position
   function void push_octants(logic finish);
      int cx, cy, wx, wy, k;
      int px[8];
      int py[8];
      circle_pixel_type p;
      cx = origin_x;
      cy = origin_y;
      wx = walk_x;
      wy = walk_y;
      px[0] = cx + wx; py[0] = cy + wy;
      px[1] = cx - wx; py[1] = cy + wy;
      px[2] = cx + wx; py[2] = cy - wy;
      px[3] = cx - wx; py[3] = cy - wy;
      px[4] = cx + wy; py[4] = cy + wx;
      px[5] = cx - wy; py[5] = cy + wx;
      px[6] = cx + wy; py[6] = cy - wx;
      px[7] = cx - wy; py[7] = cy - wx;
      for (k = 0; k < 8; k++) begin
         p.x = 14'(px[k]);
         p.y = 14'(py[k]);
         p.pixel_valid = 1'b1;
         p.last_of_step = (k == 7);
         p.done_res = (k == 7) && finish;
         pending_pixels.push_back(p);
      end
   endfunction

   function void note_command(logic cmd, logic [11:0] cx, logic [11:0] cy,
                              logic [10:0] radius);
      int nx, ny, nd;
      logic finish;
      circle_pixel_type p;
      if (cmd == mcr_pkg::CMD_START) begin
         origin_x = cx;
         origin_y = cy;
         walk_x = '0;
         walk_y = {2'b00, radius};
         decision = 18'(mcr_pkg::DEC_INIT - 2 * int'(radius));
         walking = 1'b1;
         push_octants(1'b0);
      end else if (!walking) begin
         p.x = '0;
         p.y = '0;
         p.pixel_valid = 1'b0;
         p.last_of_step = 1'b1;
         p.done_res = 1'b0;
         pending_pixels.push_back(p);
      end else begin
         walk_x = 13'(int'(walk_x) + 1);
         nx = walk_x;
         ny = walk_y;
         nd = decision;
         if (nd > 0) begin
            walk_y = 13'(ny - 1);
            ny = walk_y;
            nd = nd + 4 * (nx - ny) + mcr_pkg::DEC_DIAG;
         end else begin
            nd = nd + 4 * nx + mcr_pkg::DEC_AXIS;
         end
         decision = 18'(nd);
         finish = (ny < nx);
         push_octants(finish);
         if (finish)
            walking = 1'b0;
      end
   endfunction

   function void check_pixel(logic signed [13:0] x, logic signed [13:0] y,
                             logic pixel_valid, logic last_of_step, logic done_res);
      circle_pixel_type e;
      if (pending_pixels.size() == 0) begin
         $display("%0t: unexpected transfer x=%0d y=%0d valid=%b last=%b done=%b",
                  $time, x, y, pixel_valid, last_of_step, done_res);
         errors++;
         return;
      end
      e = pending_pixels.pop_front();
      if (x !== e.x) begin
         $display("%0t: pixel_x expected %0d actual %0d", $time, e.x, x);
         errors++;
      end
      if (y !== e.y) begin
         $display("%0t: pixel_y expected %0d actual %0d", $time, e.y, y);
         errors++;
      end
      if (pixel_valid !== e.pixel_valid) begin
         $display("%0t: pixel_valid expected %b actual %b", $time, e.pixel_valid,
                  pixel_valid);
         errors++;
      end
      if (last_of_step !== e.last_of_step) begin
         $display("%0t: last_of_step expected %b actual %b", $time, e.last_of_step,
                  last_of_step);
         errors++;
      end
      if (done_res !== e.done_res) begin
         $display("%0t: done_res expected %b actual %b", $time, e.done_res, done_res);
         errors++;
      end
   endfunction
endclass

module midpoint_circle_rasterizer_test;
   import mcr_pkg::*;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_command;
   logic [11:0]        req_center_x;
   logic [11:0]        req_center_y;
   logic [10:0]        req_radius;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [13:0] rsp_pixel_x;
   logic signed [13:0] rsp_pixel_y;
   logic               rsp_pixel_valid;
   logic               rsp_last_of_step;
   logic               rsp_done_res;

   circle_scoreboard sb = new();
   int  sent_items;
   bit  hold_request;

   midpoint_circle_rasterizer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_center_x     (req_center_x),
      .req_center_y     (req_center_y),
      .req_radius       (req_radius),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_pixel_valid  (rsp_pixel_valid),
      .rsp_last_of_step (rsp_last_of_step),
      .rsp_done_res     (rsp_done_res)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("midpoint_circle_rasterizer_test: FAIL");
      $finish;
   end

   function automatic int sender_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         return 0;
      else if (pick < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 30);
   endfunction

   // offer one item, hold it until the transfer, then maybe idle a while
   task automatic send_command(input logic cmd, input logic [11:0] cx,
                               input logic [11:0] cy, input logic [10:0] radius);
      int gap;
      req_valid <= 1'b1;
      req_command <= cmd;
      req_center_x <= cx;
      req_center_y <= cy;
      req_radius <= radius;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sb.note_command(cmd, cx, cy, radius);
      sent_items++;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_step();
      send_command(CMD_STEP, 12'($urandom), 12'($urandom), 11'($urandom));
   endtask

   task automatic walk_to_end();
      while (sb.walking)
         send_step();
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_pixel(rsp_pixel_x, rsp_pixel_y, rsp_pixel_valid, rsp_last_of_step,
                        rsp_done_res);
   end

   // receiver side back-pressure
   initial begin
      int pick;
      int n;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (150) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 4) == 0)
               repeat ($urandom_range(30, 80)) @(posedge clock);
            else
               repeat ($urandom_range(1, 24)) @(posedge clock);
            pick = $urandom_range(0, 99);
            if (pick < 60)
               n = $urandom_range(1, 2);
            else if (pick < 90)
               n = $urandom_range(3, 6);
            else
               n = $urandom_range(15, 40);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
      end
   end

   initial begin
      int  steps;
      int  directed_items;
      logic big;
      logic [10:0] radius;
      sent_items = 0;
      hold_request = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_command <= CMD_START;
      req_center_x <= '0;
      req_center_y <= '0;
      req_radius <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // step with no circle in progress
      send_step();
      // zero radius closes on the first step
      send_command(CMD_START, 12'd0, 12'd0, 11'd0);
      send_step();
      send_step();
      // extremes of center and radius, then abandoned by a new start
      send_command(CMD_START, 12'd4095, 12'd4095, 11'd2047);
      send_step();
      send_step();
      send_command(CMD_START, 12'd100, 12'd200, 11'd1);
      walk_to_end();
      send_command(CMD_START, 12'd0, 12'd0, 11'd2047);
      send_step();
      send_command(CMD_START, 12'd2048, 12'd1, 11'd2);
      walk_to_end();
      send_command(CMD_START, 12'd4095, 12'd0, 11'd5);
      walk_to_end();
      send_command(CMD_START, 12'd1365, 12'd2730, 11'd1024);
      send_step();
      directed_items = sent_items;

      // long receiver hold-off while items keep coming
      hold_request = 1'b1;
      while (sent_items < directed_items + 100) begin
         if ($urandom_range(0, 4) != 0) begin
            big = ($urandom_range(0, 6) == 0);
            radius = big ? 11'($urandom_range(0, 2047)) : 11'($urandom_range(0, 24));
            send_command(CMD_START, 12'($urandom), 12'($urandom), radius);
            if (big)
               steps = $urandom_range(1, 6);
            else if ($urandom_range(0, 3) == 0)
               steps = $urandom_range(0, 4);
            else
               steps = 100000;
            while (sb.walking && steps > 0) begin
               send_step();
               steps--;
            end
         end else begin
            send_command(1'($urandom), 12'($urandom), 12'($urandom), 11'($urandom));
         end
      end
      req_valid <= 1'b0;

      while (sb.pending_pixels.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending_pixels.size() == 0)
         $display("midpoint_circle_rasterizer_test: PASS");
      else
         $display("midpoint_circle_rasterizer_test: FAIL");
      $finish;
   end
endmodule
